>>> rtl/pcr_pkg.sv
// Shared types and constants for the permutation crossover and repair block.
`timescale 1ns / 1ps

package pcr_pkg;

  localparam int GENE_W  = 4;
  localparam int VAL_CNT = 16;
  localparam int CUT_W   = 3;

  localparam logic [CUT_W-1:0] CUT_RESET = 3'd3;

  typedef enum logic [5:0] {
    ST_LOAD   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_MISS   = 6'b000100,
    ST_MDRAIN = 6'b001000,
    ST_ERD    = 6'b010000,
    ST_ECALC  = 6'b100000
  } state_t;

  typedef struct packed {
    logic              dup;
    logic [GENE_W-1:0] val;
  } child_ent_t;

endpackage

>>> rtl/permutation_crossover_repair.sv
// One-point permutation crossover with duplicate repair, one shared sequencer.
//
//   channel  handshake               payload
//   -------  ----------------------  ---------------------------
//   in       in_valid / in_stall     gene_a, gene_b, last_in
//   out      out_valid / out_stall   child_a, child_b, last_out
//   cfg      cfg_we                  cfg_wdata (cut_point)
//
// A pair of N positions is loaded at one item per cycle. The final item starts
// a repair pass (N steps to scan the unrepaired children, N to queue the
// missing values, one to drain), then emission reads and then computes each
// position, waiting while out_stall is high; the single read port of each
// store and the read-then-use turn of the missing-value queue set that split.
// in_stall is high from the final item until the last child item sits in the
// output register. rst is synchronous and clears the sequencer, the load
// position, out_valid and cut_point (to 3).
`timescale 1ns / 1ps

module permutation_crossover_repair #(
  parameter int GENE_COUNT = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [pcr_pkg::CUT_W-1:0]   cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [pcr_pkg::GENE_W-1:0]  gene_a,
  input  logic [pcr_pkg::GENE_W-1:0]  gene_b,
  input  logic                        last_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pcr_pkg::GENE_W-1:0]  child_a,
  output logic [pcr_pkg::GENE_W-1:0]  child_b,
  output logic                        last_out
);

  localparam int POS_W = (GENE_COUNT > 1) ? $clog2(GENE_COUNT) : 1;
  localparam int CNT_W = $clog2(GENE_COUNT + 1);
  localparam int CMP_W = (POS_W > pcr_pkg::CUT_W) ? POS_W : pcr_pkg::CUT_W;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(GENE_COUNT - 1);

  pcr_pkg::state_t state;

  logic [pcr_pkg::CUT_W-1:0] cut;
  logic [POS_W-1:0]          load_pos;
  logic [POS_W-1:0]          lastpos;
  logic [POS_W-1:0]          cnt;
  logic [POS_W-1:0]          eidx;

  // Second step of the scan/queue passes: store data is registered, so it arrives in the cycle after its address.
  logic                      proc_v;
  logic                      proc_scan;
  logic [POS_W-1:0]          proc_idx;

  // Values seen so far in each unrepaired child.
  logic [pcr_pkg::VAL_CNT-1:0] seen_a;
  logic [pcr_pkg::VAL_CNT-1:0] seen_b;

  // Missing-value queue fill counts and read pointers.
  logic [CNT_W-1:0]          nma;
  logic [CNT_W-1:0]          nmb;
  logic [CNT_W-1:0]          ka;
  logic [CNT_W-1:0]          kb;

  // Stores and their registered read data.
  logic [pcr_pkg::GENE_W-1:0] pa_mem [GENE_COUNT];
  logic [pcr_pkg::GENE_W-1:0] pb_mem [GENE_COUNT];
  pcr_pkg::child_ent_t        ca_mem [GENE_COUNT];
  pcr_pkg::child_ent_t        cb_mem [GENE_COUNT];
  logic [pcr_pkg::GENE_W-1:0] ma_mem [GENE_COUNT];
  logic [pcr_pkg::GENE_W-1:0] mb_mem [GENE_COUNT];

  logic [pcr_pkg::GENE_W-1:0] pa_rd;
  logic [pcr_pkg::GENE_W-1:0] pb_rd;
  pcr_pkg::child_ent_t        ca_rd;
  pcr_pkg::child_ent_t        cb_rd;
  logic [pcr_pkg::GENE_W-1:0] ma_rd;
  logic [pcr_pkg::GENE_W-1:0] mb_rd;

  logic                       in_acc;
  logic                       in_final;
  logic                       p_re;
  logic                       e_re;
  logic                       in_prefix;
  logic [pcr_pkg::GENE_W-1:0] raw_a;
  logic [pcr_pkg::GENE_W-1:0] raw_b;
  logic                       dup_a;
  logic                       dup_b;
  logic                       push_a;
  logic                       push_b;
  logic                       use_a;
  logic                       use_b;
  logic                       out_free;

  // Accept items only while loading a pair.
  assign in_stall = (state != pcr_pkg::ST_LOAD);
  assign in_acc   = in_valid && !in_stall;
  // Treat the last store slot as final even without last_in.
  assign in_final = last_in || (load_pos == POS_LAST);

  assign p_re = (state == pcr_pkg::ST_SCAN) || (state == pcr_pkg::ST_MISS);
  assign e_re = (state == pcr_pkg::ST_ERD);

  // Child A: prefix from parent B, suffix from parent A; child B the reverse.
  assign in_prefix = (CMP_W'(proc_idx) <= CMP_W'(cut));
  assign raw_a     = in_prefix ? pb_rd : pa_rd;
  assign raw_b     = in_prefix ? pa_rd : pb_rd;
  assign dup_a     = seen_a[raw_a];
  assign dup_b     = seen_b[raw_b];

  // A suffix-parent value absent from the unrepaired child joins the queue.
  assign push_a = !seen_a[pa_rd];
  assign push_b = !seen_b[pb_rd];

  // A duplicate takes the next queued value while any remain.
  assign use_a    = ca_rd.dup && (ka < nma);
  assign use_b    = cb_rd.dup && (kb < nmb);
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pa_mem[load_pos] <= gene_a;
      pb_mem[load_pos] <= gene_b;
    end
    if (p_re) begin
      pa_rd <= pa_mem[cnt];
      pb_rd <= pb_mem[cnt];
    end
  end

  always_ff @(posedge clk) begin
    if (proc_v && proc_scan) begin
      ca_mem[proc_idx] <= '{dup: dup_a, val: raw_a};
      cb_mem[proc_idx] <= '{dup: dup_b, val: raw_b};
    end
    if (e_re) begin
      ca_rd <= ca_mem[eidx];
      cb_rd <= cb_mem[eidx];
    end
  end

  always_ff @(posedge clk) begin
    if (proc_v && !proc_scan && push_a) begin
      ma_mem[nma[POS_W-1:0]] <= pa_rd;
    end
    if (proc_v && !proc_scan && push_b) begin
      mb_mem[nmb[POS_W-1:0]] <= pb_rd;
    end
    if (e_re) begin
      ma_rd <= ma_mem[ka[POS_W-1:0]];
      mb_rd <= mb_mem[kb[POS_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pcr_pkg::ST_LOAD;
      cut       <= pcr_pkg::CUT_RESET;
      load_pos  <= '0;
      proc_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        cut <= cfg_wdata;
      end
      // Load a new child item when the register frees up in ECALC, else drop
      // valid once taken, and hold it while stalled.
      if (out_free) begin
        out_valid <= (state == pcr_pkg::ST_ECALC);
      end

      // Second step of the scan and queue passes.
      proc_v <= p_re;
      if (proc_v) begin
        if (proc_scan) begin
          seen_a[raw_a] <= 1'b1;
          seen_b[raw_b] <= 1'b1;
        end else begin
          if (push_a) nma <= nma + CNT_W'(1);
          if (push_b) nmb <= nmb + CNT_W'(1);
        end
      end

      unique case (state)
        pcr_pkg::ST_LOAD: begin
          if (in_acc) begin
            if (in_final) begin
              lastpos  <= load_pos;
              load_pos <= '0;
              cnt      <= '0;
              seen_a   <= '0;
              seen_b   <= '0;
              nma      <= '0;
              nmb      <= '0;
              state    <= pcr_pkg::ST_SCAN;
            end else begin
              load_pos <= load_pos + POS_W'(1);
            end
          end
        end
        pcr_pkg::ST_SCAN: begin
          proc_scan <= 1'b1;
          proc_idx  <= cnt;
          if (cnt == lastpos) begin
            cnt   <= '0;
            state <= pcr_pkg::ST_MISS;
          end else begin
            cnt <= cnt + POS_W'(1);
          end
        end
        pcr_pkg::ST_MISS: begin
          proc_scan <= 1'b0;
          proc_idx  <= cnt;
          if (cnt == lastpos) begin
            state <= pcr_pkg::ST_MDRAIN;
          end else begin
            cnt <= cnt + POS_W'(1);
          end
        end
        pcr_pkg::ST_MDRAIN: begin
          // Let the last queue write land before the first queue read.
          eidx  <= '0;
          ka    <= '0;
          kb    <= '0;
          state <= pcr_pkg::ST_ERD;
        end
        pcr_pkg::ST_ERD: begin
          state <= pcr_pkg::ST_ECALC;
        end
        pcr_pkg::ST_ECALC: begin
          // Hold read data until the output register frees up.
          if (out_free) begin
            child_a   <= use_a ? ma_rd : ca_rd.val;
            child_b   <= use_b ? mb_rd : cb_rd.val;
            last_out  <= (eidx == lastpos);
            if (use_a) ka <= ka + CNT_W'(1);
            if (use_b) kb <= kb + CNT_W'(1);
            if (eidx == lastpos) begin
              state <= pcr_pkg::ST_LOAD;
            end else begin
              eidx  <= eidx + POS_W'(1);
              state <= pcr_pkg::ST_ERD;
            end
          end
        end
        default: begin
          state <= pcr_pkg::ST_LOAD;
        end
      endcase
    end
  end

  // Queue read pointers never pass the fill counts.
  a_ka_bound: assert property (@(posedge clk) disable iff (rst)
    (state == pcr_pkg::ST_ECALC) |-> (ka <= nma))
    else $error("child A queue pointer past fill count");

  a_kb_bound: assert property (@(posedge clk) disable iff (rst)
    (state == pcr_pkg::ST_ECALC) |-> (kb <= nmb))
    else $error("child B queue pointer past fill count");

  // The queue holds at most one entry per loaded position.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (state == pcr_pkg::ST_ERD) |->
      ((nma <= CNT_W'(lastpos) + CNT_W'(1)) && (nmb <= CNT_W'(lastpos) + CNT_W'(1))))
    else $error("missing-value queue overfilled");

  // The final child item leaves the repair sequencer back in loading.
  a_last_load: assert property (@(posedge clk) disable iff (rst)
    ((state == pcr_pkg::ST_ECALC) && out_free && (eidx == lastpos))
      |=> (state == pcr_pkg::ST_LOAD) && out_valid && last_out)
    else $error("final child item did not return to loading");

endmodule
